FILE: rtl/core/bmpl_pkg.sv
// Shared types and constants of the bump map lighting block.
`timescale 1ns / 1ps

package bmpl_pkg;

   // Register map of the configuration port
   typedef enum logic [3:0] {
      CSR_LIGHT_X       = 4'd0,
      CSR_LIGHT_Y       = 4'd1,
      CSR_LIGHT_HEIGHT  = 4'd2,
      CSR_BUMP_DEPTH    = 4'd3,
      CSR_RED_GAIN      = 4'd4,
      CSR_GREEN_GAIN    = 4'd5,
      CSR_BLUE_GAIN     = 4'd6,
      CSR_AMBIENT_LEVEL = 4'd7
   } csr_index_type;

   // Largest height a pixel can have: 255 * (255 + 255 + 255)
   localparam logic [17:0] HEIGHT_SPAN = 18'd195075;

   // 2^60 / HEIGHT_SPAN rounded up; a product with it shifted right by 60 gives the
   // exact truncated quotient for any dividend below 2^42
   localparam logic [42:0] SLOPE_RECIP =
      43'(((64'd1 << 60) + 64'(HEIGHT_SPAN) - 64'd1) / 64'(HEIGHT_SPAN));

   localparam logic [9:0]  LIGHT_HEIGHT_RESET = 10'd30;
   localparam logic [15:0] DEPTH_RESET        = 16'h0200;
   localparam logic [15:0] GAIN_RESET         = 16'h0200;
   localparam logic [7:0]  CHANNEL_MAX        = 8'd255;

endpackage

FILE: rtl/core/bump_map_pixel_lighting_top.sv
// Top level of the bump map point light pixel shader.
`timescale 1ns / 1ps

// One pixel enters per clock whenever start is high outside reset; busy is high only
// during reset. Each pixel comes out on rsp_out_pixel with one cycle
// of rsp_strobe, in input order. The latency is set by the bit serial pipelines:
// 32 stages for the two square roots that run side by side, 34 and 20 for the two
// normalizing divisions, plus 14 stages of arithmetic around them, two of which divide
// the slopes by the height span through a multiply by its reciprocal.
// Configuration writes are always taken (csr_ready is high); write them only while no
// pixel is in flight. Indexes beyond the register map are dropped.
module bump_map_pixel_lighting_top
   import bmpl_pkg::*;
#(
   parameter int MAX_SIDE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_here_pixel,
   input  logic [31:0] req_right_pixel,
   input  logic [31:0] req_below_pixel,
   input  logic [11:0] req_column,
   input  logic [11:0] req_row,
   output logic        rsp_strobe,
   output logic [31:0] rsp_out_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int SLOPE_QW     = 24;
   localparam int SLOPE_STAGES = 2;
   localparam int ROOT_NW      = 64;
   localparam int DIV1_QW      = 34;
   localparam int DIV2_QW      = 20;
   localparam int LATENCY      = 3 + SLOPE_STAGES + 3 + ROOT_NW / 2 + 1 + DIV1_QW + 1
                                 + DIV2_QW + 4;

   // Height of a pixel: alpha * (R + G + B)
   function automatic logic [17:0] pix_height(input logic [31:0] pix);
      logic [9:0] sum;
      sum = 10'(pix[23:16]) + 10'(pix[15:8]) + 10'(pix[7:0]);
      return 18'(pix[31:24]) * 18'(sum);
   endfunction

   // Drop the fraction and clamp to one channel
   function automatic logic [7:0] sat_channel(input logic [48:0] prod);
      logic [24:0] whole;
      whole = prod[48:24];
      return (whole > 25'(CHANNEL_MAX)) ? CHANNEL_MAX : whole[7:0];
   endfunction

   // ---------------------------------------------------------------- registers
   logic [15:0] light_x_ff, light_y_ff;
   logic [9:0]  light_height_ff;
   logic [15:0] bump_depth_ff, red_gain_ff, green_gain_ff, blue_gain_ff, ambient_level_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   // Write one register per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff       <= '0;
         light_y_ff       <= '0;
         light_height_ff  <= LIGHT_HEIGHT_RESET;
         bump_depth_ff    <= DEPTH_RESET;
         red_gain_ff      <= GAIN_RESET;
         green_gain_ff    <= GAIN_RESET;
         blue_gain_ff     <= GAIN_RESET;
         ambient_level_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LIGHT_X:       light_x_ff       <= csr_data;
            CSR_LIGHT_Y:       light_y_ff       <= csr_data;
            CSR_LIGHT_HEIGHT:  light_height_ff  <= csr_data[9:0];
            CSR_BUMP_DEPTH:    bump_depth_ff    <= csr_data;
            CSR_RED_GAIN:      red_gain_ff      <= csr_data;
            CSR_GREEN_GAIN:    green_gain_ff    <= csr_data;
            CSR_BLUE_GAIN:     blue_gain_ff     <= csr_data;
            CSR_AMBIENT_LEVEL: ambient_level_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic               take;
   logic [11:0]        col_in, row_in;
   logic signed [16:0] lx_in, ly_in;
   logic               p1_vld_ff;
   logic [17:0]        p1_h0_ff, p1_hr_ff, p1_hb_ff;
   logic [31:0]        p1_pix_ff;
   logic signed [16:0] p1_lx_ff, p1_ly_ff;

   assign take   = start && !busy;
   assign col_in = ({5'b0, req_column} >= 17'(MAX_SIDE)) ? 12'(MAX_SIDE - 1) : req_column;
   assign row_in = ({5'b0, req_row} >= 17'(MAX_SIDE)) ? 12'(MAX_SIDE - 1) : req_row;
   assign lx_in  = $signed({5'b0, col_in}) - $signed({light_x_ff[15], light_x_ff});
   assign ly_in  = $signed({5'b0, row_in}) - $signed({light_y_ff[15], light_y_ff});

   // Capture heights and the light vector
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      p1_h0_ff  <= pix_height(req_here_pixel);
      p1_hr_ff  <= pix_height(req_right_pixel);
      p1_hb_ff  <= pix_height(req_below_pixel);
      p1_pix_ff <= req_here_pixel;
      p1_lx_ff  <= lx_in;
      p1_ly_ff  <= ly_in;
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [18:0] dx_in, dy_in;
   logic               p2_vld_ff;
   logic [17:0]        p2_magx_ff, p2_magy_ff;
   logic               p2_negx_ff, p2_negy_ff;
   logic [31:0]        p2_pix_ff;
   logic signed [16:0] p2_lx_ff, p2_ly_ff;

   assign dx_in = $signed({1'b0, p1_hr_ff}) - $signed({1'b0, p1_h0_ff});
   assign dy_in = $signed({1'b0, p1_hb_ff}) - $signed({1'b0, p1_h0_ff});

   // Split height differences into sign and magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_magx_ff <= dx_in[18] ? 18'(-dx_in) : dx_in[17:0];
      p2_magy_ff <= dy_in[18] ? 18'(-dy_in) : dy_in[17:0];
      p2_negx_ff <= dx_in[18];
      p2_negy_ff <= dy_in[18];
      p2_pix_ff  <= p1_pix_ff;
      p2_lx_ff   <= p1_lx_ff;
      p2_ly_ff   <= p1_ly_ff;
   end

   // ---------------------------------------------------------------- stage 3
   logic               p3_vld_ff;
   logic [33:0]        p3_mx_ff, p3_my_ff;
   logic               p3_negx_ff, p3_negy_ff;
   logic [31:0]        p3_pix_ff;
   logic signed [16:0] p3_lx_ff, p3_ly_ff;

   // Scale the differences by the bump depth
   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else begin
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_mx_ff   <= 34'(bump_depth_ff) * 34'(p2_magx_ff);
      p3_my_ff   <= 34'(bump_depth_ff) * 34'(p2_magy_ff);
      p3_negx_ff <= p2_negx_ff;
      p3_negy_ff <= p2_negy_ff;
      p3_pix_ff  <= p2_pix_ff;
      p3_lx_ff   <= p2_lx_ff;
      p3_ly_ff   <= p2_ly_ff;
   end

   // ---------------------------------------------------------------- slope division, part 1
   // The slope is (M * 256) / HEIGHT_SPAN = (M * SLOPE_RECIP) >> 52; form the product from
   // partial products of at most 17 by 22 bits
   logic [20:0]        recip_lo;
   logic [21:0]        recip_hi;
   logic               p3a_vld_ff;
   logic [37:0]        p3a_xll_ff, p3a_xhl_ff, p3a_yll_ff, p3a_yhl_ff;
   logic [38:0]        p3a_xlh_ff, p3a_xhh_ff, p3a_ylh_ff, p3a_yhh_ff;
   logic               p3a_negx_ff, p3a_negy_ff;
   logic [31:0]        p3a_pix_ff;
   logic signed [16:0] p3a_lx_ff, p3a_ly_ff;

   assign recip_lo = SLOPE_RECIP[20:0];
   assign recip_hi = SLOPE_RECIP[42:21];

   always_ff @(posedge clock) begin
      if (reset) begin
         p3a_vld_ff <= 1'b0;
      end else begin
         p3a_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3a_xll_ff  <= 38'(p3_mx_ff[16:0]) * 38'(recip_lo);
      p3a_xlh_ff  <= 39'(p3_mx_ff[16:0]) * 39'(recip_hi);
      p3a_xhl_ff  <= 38'(p3_mx_ff[33:17]) * 38'(recip_lo);
      p3a_xhh_ff  <= 39'(p3_mx_ff[33:17]) * 39'(recip_hi);
      p3a_yll_ff  <= 38'(p3_my_ff[16:0]) * 38'(recip_lo);
      p3a_ylh_ff  <= 39'(p3_my_ff[16:0]) * 39'(recip_hi);
      p3a_yhl_ff  <= 38'(p3_my_ff[33:17]) * 38'(recip_lo);
      p3a_yhh_ff  <= 39'(p3_my_ff[33:17]) * 39'(recip_hi);
      p3a_negx_ff <= p3_negx_ff;
      p3a_negy_ff <= p3_negy_ff;
      p3a_pix_ff  <= p3_pix_ff;
      p3a_lx_ff   <= p3_lx_ff;
      p3a_ly_ff   <= p3_ly_ff;
   end

   // ---------------------------------------------------------------- slope division, part 2
   logic [76:0]         px_in, py_in;
   logic                p3b_vld_ff;
   logic [SLOPE_QW-1:0] p3b_qx_ff, p3b_qy_ff;
   logic                p3b_negx_ff, p3b_negy_ff;
   logic [31:0]         p3b_pix_ff;
   logic signed [16:0]  p3b_lx_ff, p3b_ly_ff;

   assign px_in = 77'(p3a_xll_ff) + (77'(p3a_xlh_ff) << 21) + (77'(p3a_xhl_ff) << 17)
                + (77'(p3a_xhh_ff) << 38);
   assign py_in = 77'(p3a_yll_ff) + (77'(p3a_ylh_ff) << 21) + (77'(p3a_yhl_ff) << 17)
                + (77'(p3a_yhh_ff) << 38);

   // Sum the partial products and keep the integer quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         p3b_vld_ff <= 1'b0;
      end else begin
         p3b_vld_ff <= p3a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3b_qx_ff   <= px_in[75:52];
      p3b_qy_ff   <= py_in[75:52];
      p3b_negx_ff <= p3a_negx_ff;
      p3b_negy_ff <= p3a_negy_ff;
      p3b_pix_ff  <= p3a_pix_ff;
      p3b_lx_ff   <= p3a_lx_ff;
      p3b_ly_ff   <= p3a_ly_ff;
   end

   // ---------------------------------------------------------------- stage 4
   logic                p4_vld_ff;
   logic signed [24:0]  p4_sx_ff, p4_sy_ff;
   logic [SLOPE_QW-1:0] p4_qx_ff, p4_qy_ff;
   logic [31:0]         p4_pix_ff;
   logic signed [16:0]  p4_lx_ff, p4_ly_ff;

   // Restore the slope signs
   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
      end else begin
         p4_vld_ff <= p3b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p4_sx_ff  <= p3b_negx_ff ? -$signed({1'b0, p3b_qx_ff}) : $signed({1'b0, p3b_qx_ff});
      p4_sy_ff  <= p3b_negy_ff ? -$signed({1'b0, p3b_qy_ff}) : $signed({1'b0, p3b_qy_ff});
      p4_qx_ff  <= p3b_qx_ff;
      p4_qy_ff  <= p3b_qy_ff;
      p4_pix_ff <= p3b_pix_ff;
      p4_lx_ff  <= p3b_lx_ff;
      p4_ly_ff  <= p3b_ly_ff;
   end

   // ---------------------------------------------------------------- stage 5
   logic signed [33:0] lxx_in, lyy_in;
   logic               p5_vld_ff;
   logic signed [41:0] p5_pxx_ff, p5_pyy_ff;
   logic [47:0]        p5_sxx_ff, p5_syy_ff;
   logic [31:0]        p5_lxx_ff, p5_lyy_ff;
   logic [19:0]        p5_zz_ff;
   logic [31:0]        p5_pix_ff;

   assign lxx_in = 34'(p4_lx_ff) * 34'(p4_lx_ff);
   assign lyy_in = 34'(p4_ly_ff) * 34'(p4_ly_ff);

   // Form the dot product terms and the squared lengths
   always_ff @(posedge clock) begin
      if (reset) begin
         p5_vld_ff <= 1'b0;
      end else begin
         p5_vld_ff <= p4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p5_pxx_ff <= 42'(p4_sx_ff) * 42'(p4_lx_ff);
      p5_pyy_ff <= 42'(p4_sy_ff) * 42'(p4_ly_ff);
      p5_sxx_ff <= 48'(p4_qx_ff) * 48'(p4_qx_ff);
      p5_syy_ff <= 48'(p4_qy_ff) * 48'(p4_qy_ff);
      p5_lxx_ff <= lxx_in[31:0];
      p5_lyy_ff <= lyy_in[31:0];
      p5_zz_ff  <= 20'(light_height_ff) * 20'(light_height_ff);
      p5_pix_ff <= p4_pix_ff;
   end

   // ---------------------------------------------------------------- stage 6
   logic               p6_vld_ff;
   logic signed [42:0] p6_num_ff;
   logic [49:0]        p6_nsq_ff;
   logic [31:0]        p6_lsq_ff;
   logic [31:0]        p6_pix_ff;

   // Sum the terms
   always_ff @(posedge clock) begin
      if (reset) begin
         p6_vld_ff <= 1'b0;
      end else begin
         p6_vld_ff <= p5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p6_num_ff <= 43'(p5_pxx_ff) + 43'(p5_pyy_ff)
                 + $signed({17'b0, light_height_ff, 16'b0});
      p6_nsq_ff <= 50'(p5_sxx_ff) + 50'(p5_syy_ff) + (50'(1) << 32);
      p6_lsq_ff <= p5_lxx_ff + p5_lyy_ff + 32'(p5_zz_ff);
      p6_pix_ff <= p5_pix_ff;
   end

   // ---------------------------------------------------------------- vector lengths
   logic                 vrn, vrl;
   logic [ROOT_NW/2-1:0] root_n, root_l;
   logic [42:0]          num_d;
   logic [31:0]          pix_r;

   bmpl_sqrt #(.NW(ROOT_NW), .SW(43)) u_sqrt_n (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (p6_vld_ff),
      .in_radicand (ROOT_NW'(p6_nsq_ff)),
      .in_side     (p6_num_ff),
      .out_valid   (vrn),
      .out_root    (root_n),
      .out_side    (num_d)
   );

   bmpl_sqrt #(.NW(ROOT_NW), .SW(32)) u_sqrt_l (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (p6_vld_ff),
      .in_radicand ({p6_lsq_ff, 32'b0}),
      .in_side     (p6_pix_ff),
      .out_valid   (vrl),
      .out_root    (root_l),
      .out_side    (pix_r)
   );

   // ---------------------------------------------------------------- stage 7
   logic        p7_vld_ff;
   logic [41:0] p7_mag_ff;
   logic [24:0] p7_nlen_ff;
   logic        p7_neg_ff;
   logic [31:0] p7_llen_ff;
   logic [31:0] p7_pix_ff;

   // Split the numerator into sign and magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         p7_vld_ff <= 1'b0;
      end else begin
         p7_vld_ff <= vrn && vrl;
      end
   end

   always_ff @(posedge clock) begin
      p7_mag_ff  <= num_d[42] ? 42'(-num_d) : num_d[41:0];
      p7_neg_ff  <= num_d[42];
      p7_nlen_ff <= root_n[24:0];
      p7_llen_ff <= root_l;
      p7_pix_ff  <= pix_r;
   end

   // ---------------------------------------------------------------- normal division
   logic               vd1;
   logic [DIV1_QW-1:0] q1;
   logic [64:0]        side1_d;

   bmpl_div #(.DW(58), .VW(25), .QW(DIV1_QW), .SW(65)) u_div_n (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (p7_vld_ff),
      .in_dividend  ({p7_mag_ff, 16'b0}),
      .in_divisor   (p7_nlen_ff),
      .in_side      ({p7_neg_ff, p7_llen_ff, p7_pix_ff}),
      .out_valid    (vd1),
      .out_quotient (q1),
      .out_side     (side1_d)
   );

   // ---------------------------------------------------------------- stage 8
   logic               p8_vld_ff;
   logic [DIV1_QW-1:0] p8_q1_ff;
   logic [31:0]        p8_llen_ff;
   logic               p8_neg_ff;
   logic               p8_zero_ff;
   logic [31:0]        p8_pix_ff;

   // Hold the first quotient and flag a zero light length
   always_ff @(posedge clock) begin
      if (reset) begin
         p8_vld_ff <= 1'b0;
      end else begin
         p8_vld_ff <= vd1;
      end
   end

   always_ff @(posedge clock) begin
      p8_q1_ff   <= q1;
      p8_neg_ff  <= side1_d[64];
      p8_llen_ff <= side1_d[63:32];
      p8_zero_ff <= (side1_d[63:32] == '0);
      p8_pix_ff  <= side1_d[31:0];
   end

   // ---------------------------------------------------------------- light division
   logic               vd2;
   logic [DIV2_QW-1:0] q2;
   logic [33:0]        side2_d;

   bmpl_div #(.DW(50), .VW(32), .QW(DIV2_QW), .SW(34)) u_div_l (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (p8_vld_ff),
      .in_dividend  ({p8_q1_ff, 16'b0}),
      .in_divisor   (p8_llen_ff),
      .in_side      ({p8_neg_ff, p8_zero_ff, p8_pix_ff}),
      .out_valid    (vd2),
      .out_quotient (q2),
      .out_side     (side2_d)
   );

   // ---------------------------------------------------------------- stage 9
   logic signed [20:0] q2_s;
   logic signed [25:0] lit_in;
   logic               p9_vld_ff;
   logic signed [25:0] p9_shade_ff;
   logic [31:0]        p9_pix_ff;

   assign q2_s   = $signed({1'b0, q2});
   assign lit_in = side2_d[32] ? 26'sd0 : (side2_d[33] ? 26'(-q2_s) : 26'(q2_s));

   // Add ambient to the shade
   always_ff @(posedge clock) begin
      if (reset) begin
         p9_vld_ff <= 1'b0;
      end else begin
         p9_vld_ff <= vd2;
      end
   end

   always_ff @(posedge clock) begin
      p9_shade_ff <= lit_in + $signed({2'b0, ambient_level_ff, 8'b0});
      p9_pix_ff   <= side2_d[31:0];
   end

   // ---------------------------------------------------------------- stage 10
   logic [24:0] shade_pos;
   logic        p10_vld_ff;
   logic [32:0] p10_r_ff, p10_g_ff, p10_b_ff;
   logic [7:0]  p10_alpha_ff;

   assign shade_pos = (!p9_shade_ff[25] && p9_shade_ff != '0) ? p9_shade_ff[24:0] : '0;

   // Scale each channel by the shade
   always_ff @(posedge clock) begin
      if (reset) begin
         p10_vld_ff <= 1'b0;
      end else begin
         p10_vld_ff <= p9_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p10_r_ff     <= 33'(shade_pos) * 33'(p9_pix_ff[23:16]);
      p10_g_ff     <= 33'(shade_pos) * 33'(p9_pix_ff[15:8]);
      p10_b_ff     <= 33'(shade_pos) * 33'(p9_pix_ff[7:0]);
      p10_alpha_ff <= p9_pix_ff[31:24];
   end

   // ---------------------------------------------------------------- stage 11
   logic        p11_vld_ff;
   logic [48:0] p11_r_ff, p11_g_ff, p11_b_ff;
   logic [7:0]  p11_alpha_ff;

   // Apply the channel gains
   always_ff @(posedge clock) begin
      if (reset) begin
         p11_vld_ff <= 1'b0;
      end else begin
         p11_vld_ff <= p10_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p11_r_ff     <= 49'(p10_r_ff) * 49'(red_gain_ff);
      p11_g_ff     <= 49'(p10_g_ff) * 49'(green_gain_ff);
      p11_b_ff     <= 49'(p10_b_ff) * 49'(blue_gain_ff);
      p11_alpha_ff <= p10_alpha_ff;
   end

   // ---------------------------------------------------------------- stage 12
   logic        p12_vld_ff;
   logic [31:0] p12_pix_ff;

   // Clamp and pack the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         p12_vld_ff <= 1'b0;
      end else begin
         p12_vld_ff <= p11_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p12_pix_ff <= {p11_alpha_ff, sat_channel(p11_r_ff), sat_channel(p11_g_ff),
                     sat_channel(p11_b_ff)};
   end

   assign rsp_strobe    = p12_vld_ff;
   assign rsp_out_pixel = p12_pix_ff;

`ifndef SYNTHESIS
   // Every accepted beat comes out after the fixed latency
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      take |-> ##LATENCY rsp_strobe)
      else $error("accepted pixel did not come out on time");

   // No result without a pixel accepted the latency before
   a_latency_bwd: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(take, LATENCY))
      else $error("result without a matching accepted pixel");

   // Alpha passes through untouched
   a_alpha_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_out_pixel[31:24] == $past(req_here_pixel[31:24], LATENCY))
      else $error("alpha changed in flight");
`endif

endmodule

FILE: rtl/core/bmpl_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module bmpl_div #(
   parameter int DW = 42,
   parameter int VW = 18,
   parameter int QW = 24,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_dividend,
   input  logic [VW-1:0] in_divisor,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quotient,
   output logic [SW-1:0] out_side
);

   localparam int RW = (DW > VW + QW) ? DW : VW + QW;

   logic          vld_ff  [QW];
   logic [RW-1:0] rem_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [VW-1:0] dvs_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          vld_cur;
      logic [RW-1:0] rem_cur;
      logic [RW-1:0] trial;
      logic [QW-1:0] quo_cur;
      logic [VW-1:0] dvs_cur;
      logic [SW-1:0] side_cur;

      // Take the beat from the ports or from the previous stage
      if (k == 0) begin : g_head
         assign vld_cur  = in_valid;
         assign rem_cur  = RW'(in_dividend);
         assign quo_cur  = '0;
         assign dvs_cur  = in_divisor;
         assign side_cur = in_side;
      end else begin : g_link
         assign vld_cur  = vld_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign quo_cur  = quo_ff[k-1];
         assign dvs_cur  = dvs_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      // Divisor aligned to this stage's quotient bit
      assign trial = RW'(dvs_cur) << (QW - 1 - k);

      // Advance the valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_cur;
         end
      end

      // Subtract where it fits and set the quotient bit
      always_ff @(posedge clock) begin
         if (rem_cur >= trial) begin
            rem_ff[k] <= rem_cur - trial;
            quo_ff[k] <= quo_cur | (QW'(1) << (QW - 1 - k));
         end else begin
            rem_ff[k] <= rem_cur;
            quo_ff[k] <= quo_cur;
         end
         dvs_ff[k]  <= dvs_cur;
         side_ff[k] <= side_cur;
      end
   end

   assign out_valid    = vld_ff[QW-1];
   assign out_quotient = quo_ff[QW-1];
   assign out_side     = side_ff[QW-1];

endmodule

FILE: rtl/core/bmpl_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module bmpl_sqrt #(
   parameter int NW = 64,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [NW-1:0]   in_radicand,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [NW/2-1:0] out_root,
   output logic [SW-1:0]   out_side
);

   localparam int RN = NW / 2;

   logic          vld_ff  [RN];
   logic [NW-1:0] rem_ff  [RN];
   logic [NW-1:0] res_ff  [RN];
   logic [SW-1:0] side_ff [RN];

   for (genvar k = 0; k < RN; k++) begin : g_stage
      logic          vld_cur;
      logic [NW-1:0] rem_cur;
      logic [NW-1:0] res_cur;
      logic [SW-1:0] side_cur;
      logic [NW-1:0] probe;
      logic [NW-1:0] trial;

      // Take the beat from the ports or from the previous stage
      if (k == 0) begin : g_head
         assign vld_cur  = in_valid;
         assign rem_cur  = in_radicand;
         assign res_cur  = '0;
         assign side_cur = in_side;
      end else begin : g_link
         assign vld_cur  = vld_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign res_cur  = res_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      assign probe = NW'(1) << (NW - 2 - 2 * k);
      assign trial = res_cur + probe;

      // Advance the valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_cur;
         end
      end

      // Try the next root bit
      always_ff @(posedge clock) begin
         if (rem_cur >= trial) begin
            rem_ff[k] <= rem_cur - trial;
            res_ff[k] <= (res_cur >> 1) + probe;
         end else begin
            rem_ff[k] <= rem_cur;
            res_ff[k] <= res_cur >> 1;
         end
         side_ff[k] <= side_cur;
      end
   end

   assign out_valid = vld_ff[RN-1];
   assign out_root  = res_ff[RN-1][RN-1:0];
   assign out_side  = side_ff[RN-1];

endmodule
